// File: rtl/qpi_pkg.sv
`default_nettype none

package qpi_pkg;

    // Fixed field widths of the point and result transactions
    localparam int COORD_W = 10;
    localparam int LEAF_W  = 12;
    localparam int COUNT_W = 13;

    // Node flag bits
    localparam logic [1:0] FLAG_LEAF  = 2'b01;
    localparam logic [1:0] FLAG_EMPTY = 2'b10;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [LEAF_W-1:0]  leaf_idx_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef struct packed {
        coord_t point_x;
        coord_t point_y;
    } point_t;

    typedef struct packed {
        leaf_idx_t leaf_node;
        count_t    nodes_used;
        logic      pool_overflow;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_FREAD,
        ST_FWRITE,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// File: rtl/quadtree_point_insert_core.sv
`default_nettype none

// Channel   Direction  Handshake                    Payload
// point     in         point_valid / point_ready    qpi_pkg::point_t  (point_x, point_y)
// result    out        result_valid / result_ready  qpi_pkg::result_t (leaf_node, nodes_used,
//                                                   pool_overflow)
//
// One point at a time. Each tree level has a node pool read and an evaluate/write
// step; a node allocated during this insert skips the read. All pool accesses go
// through the single pool memory port pair. Reset clears only control state: the
// pool is not swept, the root reads as empty until first written and every allocated
// node is written before it can be reached again. A stalled result holds in the
// output register; the next point is taken once the result is loaded there.
module quadtree_point_insert_core #(
    parameter int WORLD_SIZE = 1024,
    parameter int MIN_CELL   = 8,
    parameter int POOL_NODES = 4096
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              point_valid,
    output logic                   point_ready,
    input  wire qpi_pkg::point_t   point,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output qpi_pkg::result_t       result
);

    localparam int IDX_W  = $clog2(POOL_NODES);
    localparam int CNT_W  = $clog2(POOL_NODES + 1);
    localparam int SIZE_W = $clog2(WORLD_SIZE + 1);
    localparam bit HAS_LEVEL = (WORLD_SIZE >= MIN_CELL);

    typedef struct packed {
        logic [1:0]                  flags;
        logic [3:0]                  valid;
        logic [3:0][IDX_W-1:0]       links;
    } entry_t;

    localparam entry_t RESET_ENTRY = '{
        flags: qpi_pkg::FLAG_LEAF | qpi_pkg::FLAG_EMPTY,
        valid: 4'b0000,
        links: '0
    };

    qpi_pkg::state_t   state_reg, state_next;
    logic [IDX_W-1:0]  node_reg, node_next;
    logic              fresh_reg, fresh_next;
    qpi_pkg::coord_t   cx_reg, cx_next;
    qpi_pkg::coord_t   cy_reg, cy_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [CNT_W-1:0]  next_free_reg, next_free_next;
    logic              root_init_reg, root_init_next;
    logic              ovf_reg, ovf_next;
    logic              out_valid_reg, out_valid_next;
    qpi_pkg::result_t  result_reg, result_next;

    entry_t            mem [POOL_NODES];
    entry_t            rd_data_reg;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_data;

    logic [SIZE_W-1:0] half;
    entry_t            cur;
    logic              sx, sy;
    logic [1:0]        q;
    logic              hit;
    logic [IDX_W-1:0]  child;
    logic [IDX_W-1:0]  child_ok;
    logic              pool_full;
    logic              deeper;
    logic [IDX_W-1:0]  alloc_idx;

    // Node pool: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Control and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= qpi_pkg::ST_IDLE;
            next_free_reg <= CNT_W'(1);
            root_init_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            fresh_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            next_free_reg <= next_free_next;
            root_init_reg <= root_init_next;
            out_valid_reg <= out_valid_next;
            fresh_reg     <= fresh_next;
            ovf_reg       <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg   <= node_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        size_reg   <= size_next;
        result_reg <= result_next;
    end

    // Pick the child quadrant of the current level; test for a full pool and a deeper level
    always_comb
    begin
        half      = size_reg >> 1;
        cur       = fresh_reg ? RESET_ENTRY : rd_data_reg;
        sx        = (32'(cx_reg) >= 32'(half));
        sy        = (32'(cy_reg) >= 32'(half));
        q         = {sy, sx};
        hit       = cur.valid[q];
        child     = cur.links[q];
        child_ok  = (32'(child) < 32'(POOL_NODES)) ? child : '0;
        pool_full = (32'(next_free_reg) >= 32'(POOL_NODES));
        deeper    = (32'(half) >= 32'(MIN_CELL));
        alloc_idx = next_free_reg[IDX_W-1:0];
    end

    // Next state, pool accesses and result load
    always_comb
    begin
        state_next     = state_reg;
        node_next      = node_reg;
        fresh_next     = fresh_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        size_next      = size_reg;
        next_free_next = next_free_reg;
        ovf_next       = ovf_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && !result_ready;
        rd_en          = 1'b0;
        rd_addr        = node_reg;
        wr_en          = 1'b0;
        wr_addr        = node_reg;
        wr_data        = cur;

        case (state_reg)
            qpi_pkg::ST_IDLE:
            begin
                if (point_valid)
                begin
                    node_next  = '0;
                    fresh_next = !root_init_reg;
                    cx_next    = point.point_x;
                    cy_next    = point.point_y;
                    size_next  = SIZE_W'(WORLD_SIZE);
                    ovf_next   = 1'b0;
                    if (HAS_LEVEL)
                    begin
                        state_next = root_init_reg ? qpi_pkg::ST_READ : qpi_pkg::ST_EVAL;
                    end
                    else
                    begin
                        state_next = root_init_reg ? qpi_pkg::ST_FREAD : qpi_pkg::ST_FWRITE;
                    end
                end
            end

            qpi_pkg::ST_READ:
            begin
                rd_en      = 1'b1;
                state_next = qpi_pkg::ST_EVAL;
            end

            qpi_pkg::ST_EVAL:
            begin
                if (!hit && pool_full)
                begin
                    // Stop the insert; a node allocated during this insert still gets its clear write
                    wr_en      = fresh_reg;
                    wr_data    = RESET_ENTRY;
                    ovf_next   = 1'b1;
                    state_next = qpi_pkg::ST_DONE;
                end
                else
                begin
                    wr_en         = 1'b1;
                    wr_data.flags = 2'b00;
                    if (!hit)
                    begin
                        wr_data.valid[q] = 1'b1;
                        wr_data.links[q] = alloc_idx;
                        next_free_next   = next_free_reg + CNT_W'(1);
                    end
                    node_next  = hit ? child_ok : alloc_idx;
                    fresh_next = !hit;
                    cx_next    = sx ? cx_reg - qpi_pkg::coord_t'(half) : cx_reg;
                    cy_next    = sy ? cy_reg - qpi_pkg::coord_t'(half) : cy_reg;
                    size_next  = half;
                    if (deeper)
                    begin
                        state_next = hit ? qpi_pkg::ST_READ : qpi_pkg::ST_EVAL;
                    end
                    else
                    begin
                        state_next = hit ? qpi_pkg::ST_FREAD : qpi_pkg::ST_FWRITE;
                    end
                end
            end

            qpi_pkg::ST_FREAD:
            begin
                rd_en      = 1'b1;
                state_next = qpi_pkg::ST_FWRITE;
            end

            qpi_pkg::ST_FWRITE:
            begin
                // Mark the deepest node occupied
                wr_en         = 1'b1;
                wr_data.flags = cur.flags & ~qpi_pkg::FLAG_EMPTY;
                state_next    = qpi_pkg::ST_DONE;
            end

            qpi_pkg::ST_DONE:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    result_next.leaf_node     = ovf_reg ? '0 : qpi_pkg::leaf_idx_t'(node_reg);
                    result_next.nodes_used    = qpi_pkg::count_t'(next_free_reg);
                    result_next.pool_overflow = ovf_reg;
                    out_valid_next            = 1'b1;
                    state_next                = qpi_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = qpi_pkg::ST_IDLE;
            end
        endcase

        root_init_next = root_init_reg || (wr_en && (wr_addr == '0));
    end

    assign point_ready  = (state_reg == qpi_pkg::ST_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

// File: rtl/qpi_checker.sv
`default_nettype none

module qpi_checker #(
    parameter int POOL_NODES = 4096
) (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             point_valid,
    input wire logic             point_ready,
    input wire qpi_pkg::point_t  point,
    input wire logic             result_valid,
    input wire logic             result_ready,
    input wire qpi_pkg::result_t result
);

    // Hold a stalled point transaction
    a_point_hold: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && !point_ready |=> point_valid && $stable(point))
        else $error("point changed or dropped while stalled");

    // Hold a stalled result transaction
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed or dropped while stalled");

    // Drop ready after a point transaction: one insert at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && point_ready |=> !point_ready)
        else $error("point accepted while an insert is in progress");

    // Report node zero on overflow
    a_ovf_leaf: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.pool_overflow |-> result.leaf_node == '0)
        else $error("overflow result with nonzero leaf node");

    // Overflow only with the pool fully allocated
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.pool_overflow |->
            result.nodes_used == qpi_pkg::count_t'(POOL_NODES))
        else $error("overflow result with pool not full");

endmodule

bind quadtree_point_insert_core qpi_checker #(
    .POOL_NODES(POOL_NODES)
) u_qpi_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .point_valid  (point_valid),
    .point_ready  (point_ready),
    .point        (point),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire
